// File: src/priority_job_queue_unit_assert.svh
// Assertion macros shared by the priority job queue RTL.
`ifndef PRIORITY_JOB_QUEUE_UNIT_ASSERT_SVH
`define PRIORITY_JOB_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PJQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PJQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/pjq_pkg.sv
// Package: sizes, codes and types of the priority job queue.
package pjq_pkg;

    localparam int DEPTH     = 16;
    localparam int PRIO_W    = 8;
    localparam int PAYLOAD_W = 32;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_ZERO_PRIO = 2'd2,
        STATUS_EMPTY     = 2'd3
    } status_t;

    typedef enum logic {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } cmd_t;

    typedef enum logic {
        FSM_IDLE,
        FSM_SCAN
    } fsm_t;

    typedef struct packed {
        logic [PRIO_W-1:0]    prio;
        logic [PAYLOAD_W-1:0] payload;
    } job_t;

    typedef struct packed {
        status_t           status;
        logic              out_valid;
        job_t              out_job;
        logic              head_valid;
        job_t              head_job;
        logic [CNT_W-1:0]  job_count;
        logic              is_full;
        logic              is_empty;
    } result_t;

    // Access bundle for the job memory.
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        job_t             wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } ram_req_t;

endpackage

// File: src/pjq_req_if.sv
// Request channel: command items into the queue.
interface pjq_req_if;
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic [pjq_pkg::PRIO_W-1:0]    in_priority;
    logic [pjq_pkg::PAYLOAD_W-1:0] in_payload;

    modport source (output valid, cmd, in_priority, in_payload, input ready);
    modport sink   (input valid, cmd, in_priority, in_payload, output ready);
endinterface

// File: src/pjq_rsp_if.sv
// Response channel: result items out of the queue.
interface pjq_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   status;
    logic                         out_valid;
    logic [pjq_pkg::PRIO_W-1:0]    out_priority;
    logic [pjq_pkg::PAYLOAD_W-1:0] out_payload;
    logic                         head_valid;
    logic [pjq_pkg::PRIO_W-1:0]    head_priority;
    logic [pjq_pkg::PAYLOAD_W-1:0] head_payload;
    logic [pjq_pkg::CNT_W-1:0]     job_count;
    logic                         is_full;
    logic                         is_empty;

    modport source (output valid, status, out_valid, out_priority, out_payload,
                    head_valid, head_priority, head_payload, job_count, is_full,
                    is_empty, input ready);
    modport sink   (input valid, status, out_valid, out_priority, out_payload,
                    head_valid, head_priority, head_payload, job_count, is_full,
                    is_empty, output ready);
endinterface

// File: src/pjq_job_ram.sv
// Job memory: one write and one registered read per cycle.
module pjq_job_ram (
    input  logic              clk,
    input  pjq_pkg::ram_req_t req,
    output pjq_pkg::job_t     rdata
);
    import pjq_pkg::*;

    job_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end

endmodule

// File: src/priority_job_queue_unit.sv
// Top level: bounded min-first priority job queue over a job memory.
// Enqueue, and dequeue from a queue of at most one job: the result is registered at the
// accepting edge; one item every cycle while the result side keeps up.
// Dequeue from c >= 2 jobs: the result is registered when the close-up scan ends; the scan reads
// one job memory entry per cycle, and no new item is taken until it is done.
// Reset (rst_n low, asynchronous) empties the queue; the job memory is not cleared.
module priority_job_queue_unit (
    input  logic  clk,
    input  logic  rst_n,
    pjq_req_if.sink   req,
    pjq_rsp_if.source rsp
);
    import pjq_pkg::*;

    `include "priority_job_queue_unit_assert.svh"

    // Control state
    fsm_t             state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic             issuing_reg, issuing_next;
    logic             dvalid_reg, dvalid_next;

    // Datapath state
    job_t             head_reg, head_next;
    logic [IDX_W-1:0] head_idx_reg, head_idx_next;
    result_t          rsp_reg, rsp_next;
    logic [IDX_W-1:0] rm_idx_reg, rm_idx_next;
    logic [IDX_W-1:0] issue_pos_reg, issue_pos_next;
    logic [IDX_W-1:0] last_pos_reg, last_pos_next;
    logic [IDX_W-1:0] dpos_reg, dpos_next;
    job_t             best_reg, best_next;
    logic [IDX_W-1:0] best_pos_reg, best_pos_next;
    job_t             deq_job_reg, deq_job_next;

    // Combinational helpers
    logic             accept;
    logic             is_deq;
    logic             full;
    logic             empty;
    logic             enq_ok;
    logic [IDX_W-1:0] cnt_idx;
    logic [CNT_W-1:0] cnt_minus2;
    job_t             in_job;
    job_t             rd_job;
    logic             last_data;
    logic             scan_take;
    job_t             scan_job;
    logic [IDX_W-1:0] scan_pos;
    ram_req_t         ram_req;

    // Pack one result item; the head reads as zero when the queue ends empty.
    function automatic result_t make_result(status_t st, logic ov, job_t oj,
                                            job_t hj, logic [CNT_W-1:0] cnt);
        result_t r;
        r.status     = st;
        r.out_valid  = ov;
        r.out_job    = ov ? oj : '0;
        r.head_valid = (cnt != '0);
        r.head_job   = (cnt != '0) ? hj : '0;
        r.job_count  = cnt;
        r.is_full    = (cnt == CNT_W'(DEPTH));
        r.is_empty   = (cnt == '0);
        return r;
    endfunction

    assign accept     = req.valid && req.ready;
    assign is_deq     = (cmd_t'(req.cmd) == CMD_DEQ);
    assign full       = (count_reg == CNT_W'(DEPTH));
    assign empty      = (count_reg == '0);
    assign cnt_idx    = count_reg[IDX_W-1:0];
    assign cnt_minus2 = count_reg - CNT_W'(2);
    assign in_job     = '{prio: req.in_priority, payload: req.in_payload};
    assign enq_ok     = accept && !is_deq && !full && (req.in_priority != '0);
    assign last_data  = dvalid_reg && (dpos_reg == last_pos_reg);

    // Running minimum of the scan: strict compare keeps the earliest job on ties.
    assign scan_take = (dpos_reg == '0) || (rd_job.prio < best_reg.prio);
    assign scan_job  = scan_take ? rd_job : best_reg;
    assign scan_pos  = scan_take ? dpos_reg : best_pos_reg;

    pjq_job_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (rd_job)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                if (accept && is_deq && (count_reg > CNT_W'(1)))
                begin
                    state_next = FSM_SCAN;
                end
            end
            FSM_SCAN:
            begin
                if (last_data)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // Outputs: handshake and memory accesses
    always_comb
    begin
        req.ready     = (state_reg == FSM_IDLE) && (!rsp_valid_reg || rsp.ready);
        ram_req.re    = issuing_reg;
        ram_req.raddr = (issue_pos_reg < rm_idx_reg) ? issue_pos_reg
                                                     : issue_pos_reg + IDX_W'(1);
        if (enq_ok)
        begin
            // Append the new job at the tail.
            ram_req.we    = 1'b1;
            ram_req.waddr = cnt_idx;
            ram_req.wdata = in_job;
        end
        else
        begin
            // Close up: jobs behind the removed one move down by one entry.
            ram_req.we    = dvalid_reg && (dpos_reg >= rm_idx_reg);
            ram_req.waddr = dpos_reg;
            ram_req.wdata = rd_job;
        end
    end

    // Datapath next values
    always_comb
    begin
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_next       = rsp_reg;
        issuing_next   = issuing_reg;
        issue_pos_next = issue_pos_reg;
        dvalid_next    = issuing_reg;
        dpos_next      = issue_pos_reg;
        head_next      = head_reg;
        head_idx_next  = head_idx_reg;
        rm_idx_next    = rm_idx_reg;
        last_pos_next  = last_pos_reg;
        best_next      = best_reg;
        best_pos_next  = best_pos_reg;
        deq_job_next   = deq_job_reg;

        // Advance the read pointer of the scan.
        if (issuing_reg)
        begin
            issue_pos_next = issue_pos_reg + IDX_W'(1);
            if (issue_pos_reg == last_pos_reg)
            begin
                issuing_next = 1'b0;
            end
        end

        // Fold each returned job into the running minimum.
        if (dvalid_reg)
        begin
            best_next     = scan_job;
            best_pos_next = scan_pos;
            if (last_data)
            begin
                head_next      = scan_job;
                head_idx_next  = scan_pos;
                rsp_next       = make_result(STATUS_OK, 1'b1, deq_job_reg, scan_job,
                                             count_reg);
                rsp_valid_next = 1'b1;
            end
        end

        if (accept)
        begin
            if (!is_deq)
            begin
                if (full)
                begin
                    rsp_next = make_result(STATUS_FULL, 1'b0, '0, head_reg, count_reg);
                end
                else if (req.in_priority == '0)
                begin
                    rsp_next = make_result(STATUS_ZERO_PRIO, 1'b0, '0, head_reg,
                                           count_reg);
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    if (empty || (req.in_priority < head_reg.prio))
                    begin
                        head_next     = in_job;
                        head_idx_next = cnt_idx;
                    end
                    rsp_next = make_result(STATUS_OK, 1'b0, '0, head_next, count_next);
                end
                rsp_valid_next = 1'b1;
            end
            else if (empty)
            begin
                rsp_next       = make_result(STATUS_EMPTY, 1'b0, '0, head_reg, count_reg);
                rsp_valid_next = 1'b1;
            end
            else
            begin
                count_next = count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1))
                begin
                    rsp_next       = make_result(STATUS_OK, 1'b1, head_reg, head_reg,
                                                 count_next);
                    rsp_valid_next = 1'b1;
                end
                else
                begin
                    // Hold the removed job and start the close-up scan.
                    deq_job_next   = head_reg;
                    rm_idx_next    = head_idx_reg;
                    issue_pos_next = '0;
                    issuing_next   = 1'b1;
                    last_pos_next  = cnt_minus2[IDX_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            issuing_reg   <= 1'b0;
            dvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            issuing_reg   <= issuing_next;
            dvalid_reg    <= dvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg      <= head_next;
        head_idx_reg  <= head_idx_next;
        rsp_reg       <= rsp_next;
        rm_idx_reg    <= rm_idx_next;
        issue_pos_reg <= issue_pos_next;
        last_pos_reg  <= last_pos_next;
        dpos_reg      <= dpos_next;
        best_reg      <= best_next;
        best_pos_reg  <= best_pos_next;
        deq_job_reg   <= deq_job_next;
    end

    // Drive the result channel from the output register.
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = rsp_reg.status;
    assign rsp.out_valid     = rsp_reg.out_valid;
    assign rsp.out_priority  = rsp_reg.out_job.prio;
    assign rsp.out_payload   = rsp_reg.out_job.payload;
    assign rsp.head_valid    = rsp_reg.head_valid;
    assign rsp.head_priority = rsp_reg.head_job.prio;
    assign rsp.head_payload  = rsp_reg.head_job.payload;
    assign rsp.job_count     = rsp_reg.job_count;
    assign rsp.is_full       = rsp_reg.is_full;
    assign rsp.is_empty      = rsp_reg.is_empty;

    // The close-up never writes the entry it reads in the same cycle.
    `PJQ_ASSERT_IMP(a_no_rw_clash, ram_req.we && ram_req.re, ram_req.waddr != ram_req.raddr, "job memory read and write hit the same entry")
    // A stored enqueue grows the queue by exactly one.
    `PJQ_ASSERT_NXT(a_enq_count, enq_ok, count_reg == $past(count_reg) + 1'b1, "enqueue did not grow the job count")
    // A dequeued job never ranks below the job left at the head.
    `PJQ_ASSERT_IMP(a_deq_order, rsp.valid && rsp.out_valid && rsp.head_valid, rsp.out_priority <= rsp.head_priority, "dequeued job is not the best held job")
    // Head flag agrees with the reported count.
    `PJQ_ASSERT_IMP(a_head_count, rsp.valid, rsp.head_valid == (rsp.job_count != '0), "head flag disagrees with job count")
    // No new item is taken while a close-up scan is running.
    `PJQ_ASSERT_IMP(a_scan_busy, issuing_reg || dvalid_reg, !accept, "item accepted during close-up scan")

endmodule
